// ===== src/psa_pkg.sv =====
// Shared widths, register indexes and types of the particle slot age block.
// Used by psa_cfg, psa_mul, psa_div and particle_slot_age; depends on nothing.
package psa_pkg;

    localparam int SLOT_W    = 16;   // slot count and slot index
    localparam int TIME_W    = 32;   // signed Q16.16 times
    localparam int LIFE_W    = 31;   // lifetime and age
    localparam int GEN_W     = 32;   // saturating generation
    localparam int MC_W      = 34;   // multiplicand of the serial multiplier
    localparam int MP_W      = 16;   // multiplier, consumed one bit per cycle
    localparam int PROD_W    = MC_W + MP_W;
    localparam int DVD_W     = 48;   // dividend, one quotient bit per cycle
    localparam int DVS_W     = 47;   // divisor and remainder
    localparam int MUL_CNT_W = $clog2(MP_W);
    localparam int DIV_CNT_W = $clog2(DVD_W);
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [1:0] REG_SLOT_COUNT   = 2'd0;
    localparam logic [1:0] REG_WINDOW_START = 2'd1;
    localparam logic [1:0] REG_WINDOW_END   = 2'd2;
    localparam logic [1:0] REG_LIFETIME     = 2'd3;

    typedef struct packed {
        logic [SLOT_W-1:0]        slot_count;
        logic signed [TIME_W-1:0] window_start;
        logic signed [TIME_W-1:0] window_end;
        logic [LIFE_W-1:0]        lifetime;
    } t_cfg;

endpackage

// ===== src/psa_cfg.sv =====
// Configuration register file behind the APB-style port.
// Depends on psa_pkg for the register indexes and the t_cfg type.
module psa_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [psa_pkg::ADDR_W-1:0]    paddr,
    input  logic [psa_pkg::DATA_W-1:0]    pwdata,
    output logic [psa_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output psa_pkg::t_cfg                 o_cfg
);

    psa_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                psa_pkg::REG_SLOT_COUNT:   r_cfg.slot_count   <= pwdata[psa_pkg::SLOT_W-1:0];
                psa_pkg::REG_WINDOW_START: r_cfg.window_start <= $signed(pwdata);
                psa_pkg::REG_WINDOW_END:   r_cfg.window_end   <= $signed(pwdata);
                psa_pkg::REG_LIFETIME:     r_cfg.lifetime     <= pwdata[psa_pkg::LIFE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            psa_pkg::REG_SLOT_COUNT:   prdata = {16'd0, r_cfg.slot_count};
            psa_pkg::REG_WINDOW_START: prdata = r_cfg.window_start;
            psa_pkg::REG_WINDOW_END:   prdata = r_cfg.window_end;
            psa_pkg::REG_LIFETIME:     prdata = {1'b0, r_cfg.lifetime};
            default:                   prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

endmodule

// ===== src/psa_mul.sv =====
// Bit-serial shift-and-add multiplier: signed multiplicand by unsigned multiplier.
// Depends on psa_pkg for its widths.
module psa_mul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [psa_pkg::MC_W-1:0]   i_mcand,
    input  logic [psa_pkg::MP_W-1:0]          i_mplier,
    output logic signed [psa_pkg::PROD_W-1:0] o_prod,
    output logic                              o_done
);

    logic                               r_busy;
    logic                               r_done;
    logic [psa_pkg::MUL_CNT_W-1:0]      r_cnt;
    logic signed [psa_pkg::PROD_W-1:0]  r_acc;
    logic signed [psa_pkg::PROD_W-1:0]  r_mc;
    logic [psa_pkg::MP_W-1:0]           r_mp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == psa_pkg::MUL_CNT_W'(psa_pkg::MP_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_mc  <= psa_pkg::PROD_W'(i_mcand);
            r_mp  <= i_mplier;
        end else if (r_busy) begin
            if (r_mp[0]) begin
                r_acc <= r_acc + r_mc;
            end
            r_mc <= r_mc <<< 1;
            r_mp <= r_mp >> 1;
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;

endmodule

// ===== src/psa_div.sv =====
// Restoring divider producing one quotient bit per cycle, shared by both divisions.
// Depends on psa_pkg for its widths.
module psa_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [psa_pkg::DVD_W-1:0]    i_dividend,
    input  logic [psa_pkg::DVS_W-1:0]    i_divisor,
    output logic [psa_pkg::DVD_W-1:0]    o_quot,
    output logic [psa_pkg::DVS_W-1:0]    o_rem,
    output logic                         o_done
);

    logic                           r_busy;
    logic                           r_done;
    logic [psa_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [psa_pkg::DVD_W-1:0]      r_quo;
    logic [psa_pkg::DVS_W-1:0]      r_rem;
    logic [psa_pkg::DVS_W-1:0]      r_dvs;
    logic [psa_pkg::DVS_W:0]        w_trial;
    logic [psa_pkg::DVS_W:0]        w_diff;
    logic                           w_ge;

    assign w_trial = {r_rem, r_quo[psa_pkg::DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == psa_pkg::DIV_CNT_W'(psa_pkg::DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[psa_pkg::DVD_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[psa_pkg::DVS_W-1:0] : w_trial[psa_pkg::DVS_W-1:0];
        end
    end

    assign o_quot = r_quo;
    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

// ===== src/particle_slot_age.sv =====
// Top level of the particle slot age block: stream channels, FSM and result register.
// Depends on psa_pkg, psa_cfg, psa_mul and psa_div.
//
// Usage. Configuration is to be written over the APB-style port while the block is idle;
// the block does not enforce this. Each request on the slave stream carries an opcode
// in tuser and a slot index and query time in tdata. Opcode 0 asks whether one slot
// holds a living particle and returns its age and generation; opcode 1 returns the
// number of live slots. Every request gives exactly one result on the master stream.
// A request first runs four serial multipliers in parallel, which form the scaled
// time, window, period and slot offset. If the emitter is not live or the slot is
// not yet born, the result follows without a division. Otherwise a slot query takes
// one division for the generation and another for the age; a slot found dead after
// the first division skips the second. A count takes one division and then walks
// the slots one per cycle, keeping the remainder up to date by subtraction. For a
// slot query the serial divider sets the rate.
// One request is in flight at a time; a new request is taken as soon as the
// previous one has reached the output register, even if that result is still
// waiting there. When the receiver stalls, the finished result holds in the
// output register and the next computed result waits in the FSM until it drains.
// Reset clears the configuration registers, empties the output register and
// leaves the block ready for a request.
module particle_slot_age (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [47:0]                  i_s_axis_tdata,  // slot_index, query_time
    input  logic                         i_s_axis_tuser,  // opcode
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [79:0]                  o_m_axis_tdata,  // alive, age, generation, live_count
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [psa_pkg::ADDR_W-1:0]   paddr,
    input  logic [psa_pkg::DATA_W-1:0]   pwdata,
    output logic [psa_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_MUL     = 6'b000010,
        ST_DIV_GEN = 6'b000100,
        ST_DIV_AGE = 6'b001000,
        ST_SCAN    = 6'b010000,
        ST_OUT     = 6'b100000
    } t_state;

    localparam int PW = psa_pkg::PROD_W;

    t_state                                r_state;
    psa_pkg::t_cfg                         w_cfg;

    logic                                  w_accept;
    logic                                  w_op_in;
    logic [psa_pkg::SLOT_W-1:0]            w_slot_in;
    logic signed [psa_pkg::TIME_W-1:0]     w_time_in;
    logic signed [psa_pkg::MC_W-1:0]       w_mc_t;
    logic signed [psa_pkg::MC_W-1:0]       w_mc_w;
    logic signed [psa_pkg::MC_W-1:0]       w_mc_life;
    logic [psa_pkg::MP_W-1:0]              w_mp_slot;

    logic signed [PW-1:0]                  p_t;
    logic signed [PW-1:0]                  p_w;
    logic signed [PW-1:0]                  p_d;
    logic signed [PW-1:0]                  p_j;
    logic                                  d_t, d_w, d_d, d_j;
    logic                                  w_mul_done;

    logic                                  w_div_start;
    logic [psa_pkg::DVD_W-1:0]             w_div_dvd;
    logic [psa_pkg::DVS_W-1:0]             w_div_dvs;
    logic [psa_pkg::DVD_W-1:0]             w_div_quot;
    logic [psa_pkg::DVS_W-1:0]             w_div_rem;
    logic                                  w_div_done;

    logic                                  w_enabled;
    logic signed [PW:0]                    w_rem;
    logic signed [PW:0]                    w_sum_gen;
    logic signed [PW:0]                    w_sum_scan;
    logic [psa_pkg::DVS_W:0]               w_r_step;
    logic                                  w_scan_alive;
    logic [psa_pkg::SLOT_W-1:0]            w_cnt_next;

    logic                                  r_op;
    logic signed [PW:0]                    r_diff;
    logic signed [PW-1:0]                  r_q;
    logic [psa_pkg::DVS_W-1:0]             r_r;
    logic [psa_pkg::SLOT_W-1:0]            r_idx;
    logic [psa_pkg::SLOT_W-1:0]            r_cnt;
    logic                                  r_alive;
    logic [psa_pkg::LIFE_W-1:0]            r_age;
    logic [psa_pkg::GEN_W-1:0]             r_gen;
    logic [psa_pkg::SLOT_W-1:0]            r_live;

    logic                                  r_m_valid;
    logic                                  r_o_alive;
    logic [psa_pkg::LIFE_W-1:0]            r_o_age;
    logic [psa_pkg::GEN_W-1:0]             r_o_gen;
    logic [psa_pkg::SLOT_W-1:0]            r_o_live;
    logic                                  w_out_load;

    psa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Request decode and multiplier operands.
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_op_in         = i_s_axis_tuser;
    assign w_slot_in       = i_s_axis_tdata[15:0];
    assign w_time_in       = $signed(i_s_axis_tdata[47:16]);

    assign w_mc_t    = psa_pkg::MC_W'(w_time_in) - psa_pkg::MC_W'(w_cfg.window_start);
    assign w_mc_w    = psa_pkg::MC_W'(w_cfg.window_end) - psa_pkg::MC_W'(w_cfg.window_start);
    assign w_mc_life = $signed({3'b000, w_cfg.lifetime});
    // A count starts at slot zero, so its slot offset is zero.
    assign w_mp_slot = w_op_in ? '0 : w_slot_in;

    psa_mul u_mul_t (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_accept),
        .i_mcand(w_mc_t), .i_mplier(w_cfg.slot_count), .o_prod(p_t), .o_done(d_t)
    );
    psa_mul u_mul_w (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_accept),
        .i_mcand(w_mc_w), .i_mplier(w_cfg.slot_count), .o_prod(p_w), .o_done(d_w)
    );
    psa_mul u_mul_d (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_accept),
        .i_mcand(w_mc_life), .i_mplier(w_cfg.slot_count), .o_prod(p_d), .o_done(d_d)
    );
    psa_mul u_mul_j (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_accept),
        .i_mcand(w_mc_life), .i_mplier(w_mp_slot), .o_prod(p_j), .o_done(d_j)
    );

    assign w_mul_done = d_t && d_w && d_d && d_j;

    // The emitter is live only with slots, a non-empty window and a lifetime.
    assign w_enabled = (w_cfg.slot_count != '0) && (w_cfg.window_end > w_cfg.window_start)
                       && (w_cfg.lifetime != '0);

    // Scaled distance from the slot's first birth; negative means not yet born.
    assign w_rem = $signed({p_t[PW-1], p_t}) - $signed({p_j[PW-1], p_j});

    // The generation is within the window exactly when the scaled window end
    // minus the query time, plus the remainder, stays non-negative.
    assign w_sum_gen  = r_diff + $signed({{(PW + 1 - psa_pkg::DVS_W){1'b0}}, w_div_rem});
    assign w_sum_scan = r_diff + $signed({{(PW + 1 - psa_pkg::DVS_W){1'b0}}, r_r});

    // One slot further on, the distance shrinks by one lifetime.
    assign w_r_step     = {1'b0, r_r} - {{(psa_pkg::DVS_W - psa_pkg::LIFE_W + 1){1'b0}},
                                         w_cfg.lifetime};
    assign w_scan_alive = !r_q[PW-1] && !w_sum_scan[PW];
    assign w_cnt_next   = r_cnt + psa_pkg::SLOT_W'(w_scan_alive);

    // Shared divider: generation and remainder first, age second.
    always_comb begin
        w_div_start = 1'b0;
        w_div_dvd   = w_rem[psa_pkg::DVD_W-1:0];
        w_div_dvs   = p_d[psa_pkg::DVS_W-1:0];
        case (r_state)
            ST_MUL: begin
                w_div_start = w_mul_done && w_enabled && !w_rem[PW];
            end
            ST_DIV_GEN: begin
                w_div_start = w_div_done && !r_op && !w_sum_gen[PW];
                w_div_dvd   = {1'b0, w_div_rem};
                w_div_dvs   = {{(psa_pkg::DVS_W - psa_pkg::SLOT_W){1'b0}}, w_cfg.slot_count};
            end
            default: ;
        endcase
    end

    psa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem),
        .o_done     (w_div_done)
    );

    assign w_out_load = (r_state == ST_OUT) && (!r_m_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (w_mul_done) begin
                        r_state <= w_div_start ? ST_DIV_GEN : ST_OUT;
                    end
                end
                ST_DIV_GEN: begin
                    if (w_div_done) begin
                        if (r_op) begin
                            r_state <= ST_SCAN;
                        end else begin
                            r_state <= w_div_start ? ST_DIV_AGE : ST_OUT;
                        end
                    end
                end
                ST_DIV_AGE: begin
                    if (w_div_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_SCAN: begin
                    if (r_idx == w_cfg.slot_count - 1'b1) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Working registers; every request starts from a dead, zero result.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_op    <= w_op_in;
                    r_alive <= 1'b0;
                    r_age   <= '0;
                    r_gen   <= '0;
                    r_live  <= '0;
                end
            end
            ST_MUL: begin
                r_diff <= $signed({p_w[PW-1], p_w}) - $signed({p_t[PW-1], p_t});
            end
            ST_DIV_GEN: begin
                if (w_div_done) begin
                    r_q   <= $signed(PW'(w_div_quot));
                    r_r   <= w_div_rem;
                    r_idx <= '0;
                    r_cnt <= '0;
                    r_gen <= (|w_div_quot[psa_pkg::DVD_W-1:psa_pkg::GEN_W]) ? '1
                             : w_div_quot[psa_pkg::GEN_W-1:0];
                end
            end
            ST_DIV_AGE: begin
                if (w_div_done) begin
                    r_alive <= 1'b1;
                    r_age   <= w_div_quot[psa_pkg::LIFE_W-1:0];
                end
            end
            ST_SCAN: begin
                r_cnt  <= w_cnt_next;
                r_live <= w_cnt_next;
                r_idx  <= r_idx + 1'b1;
                if (w_r_step[psa_pkg::DVS_W]) begin
                    r_r <= w_r_step[psa_pkg::DVS_W-1:0] + p_d[psa_pkg::DVS_W-1:0];
                    r_q <= r_q - 1'b1;
                end else begin
                    r_r <= w_r_step[psa_pkg::DVS_W-1:0];
                end
            end
            default: ;
        endcase
        // A count never reports a generation.
        if (r_state == ST_OUT && r_op) begin
            r_gen <= '0;
        end
    end

    // A dead slot, such as one whose generation falls past the window, and a count report no generation.
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_alive <= r_alive;
            r_o_age   <= r_age;
            r_o_gen   <= (r_op || !r_alive) ? '0 : r_gen;
            r_o_live  <= r_live;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {r_o_live, r_o_gen, r_o_age, r_o_alive};

    // A live slot never comes with a live count.
    a_alive_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[0]) |-> (o_m_axis_tdata[79:64] == '0))
        else $error("live slot result carries a count");

    // A dead slot has neither age nor generation.
    a_dead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[0])
        |-> (o_m_axis_tdata[31:1] == '0 && o_m_axis_tdata[63:32] == '0))
        else $error("dead slot result carries age or generation");

    // The age of a living particle stays below its lifetime.
    a_age_below_life: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[0]) |-> (o_m_axis_tdata[31:1] < w_cfg.lifetime))
        else $error("age reaches lifetime");

    // During the walk the remainder stays below one scaled period.
    a_scan_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_r < p_d[psa_pkg::DVS_W-1:0]))
        else $error("slot walk remainder out of range");

endmodule
